/* src/cpv_pkg.sv */
package cpv_pkg;

  // Fixed layout of the chat packet
  localparam int NAME_FIELD_BYTES  = 24;
  localparam int MAX_MESSAGE_BYTES = 255;
  localparam int NAME_MAX_BYTES    = 23;
  localparam int HEADER_BYTES      = 4;
  localparam int MIN_PACKET_BYTES  = HEADER_BYTES + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_NAME_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_LEN  = 2'd3;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_OVER_AVAIL   = 3'd1;
  localparam logic [2:0] ST_UNDER_MIN    = 3'd2;
  localparam logic [2:0] ST_NAME_MISMATCH = 3'd3;
  localparam logic [2:0] ST_NAME_SHORT   = 3'd4;
  localparam logic [2:0] ST_NAME_UNTERM  = 3'd5;
  localparam logic [2:0] ST_LEN_MISMATCH = 3'd6;
  localparam logic [2:0] ST_TOO_LONG     = 3'd7;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_BODY
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        packet_start;
    logic        packet_format;
    logic [15:0] bytes_available;
  } cpv_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       disconnect;
    logic [4:0] found_name_len;
    logic [4:0] message_offset;
    logic [7:0] message_length;
  } cpv_out_t;

  typedef struct packed {
    logic [NAME_MAX_BYTES*8-1:0] name;
    logic [4:0]                  name_len;
  } cpv_cfg_t;

  typedef struct packed {
    logic     emit;
    cpv_out_t res;
  } cpv_verdict_t;

endpackage

/* src/chat_packet_validator_unit.sv */
// Chat packet validator: checks a chat packet that streams in one byte per
// transaction and returns at most one verdict transaction per packet.
// Input channel (in_valid / in_stall / in_data): one packet byte per
// transaction, with packet_start, format and buffered byte count sampled
// on the first byte. A start mid-packet drops the old packet silently.
// Result channel (out_valid / out_stall / out_data): status, disconnect
// flag and, for an accepted packet, name length, message offset and length.
// Configuration port (cfg_we / cfg_index / cfg_data): speaker name bytes
// and name length; write only between packets.
// Throughput: one byte per cycle, sustained while no held result blocks a
// verdict byte. The input register and the result register bound a single
// pass of parse logic. The verdict is registered when the deciding byte
// (header byte 3 or the last byte) fires out of the input register.
// Stall: a held result blocks only a byte that would produce a new verdict;
// bytes that produce no verdict keep flowing while the result waits.
// Reset (rst_n low, synchronous): parser idle, parser and configuration
// registers cleared, both channels empty; no further clearing is needed.
module chat_packet_validator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cpv_pkg::cpv_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cpv_pkg::cpv_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [cpv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpv_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                  s1_valid_r;
  cpv_pkg::cpv_in_t      s1_item_r;
  logic                  s1_go;
  logic                  fire;
  logic                  out_valid_r;
  cpv_pkg::cpv_out_t     out_data_r;
  cpv_pkg::cpv_cfg_t     cfg;
  cpv_pkg::cpv_verdict_t vd;

  cpv_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cpv_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .cfg   (cfg),
    .vd    (vd)
  );

  // hold the staged byte only when its verdict meets a full, stalled result slot
  assign s1_go    = !(vd.emit && out_valid_r && out_stall);
  assign fire     = s1_valid_r && s1_go;
  assign in_stall = s1_valid_r && !s1_go;

  // input register: advance whenever the staged byte moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item_r <= in_data;
    end
  end

  // result register: load a fresh verdict, drop a delivered one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && vd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && vd.emit) begin
      out_data_r <= vd.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/cpv_cfg_regs.sv */
module cpv_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cpv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpv_pkg::CFG_DATA_W-1:0]   cfg_data,
  output cpv_pkg::cpv_cfg_t                cfg
);

  logic [63:0] name_low_r;
  logic [63:0] name_mid_r;
  logic [55:0] name_high_r;
  logic [4:0]  name_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_low_r  <= '0;
      name_mid_r  <= '0;
      name_high_r <= '0;
      name_len_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cpv_pkg::CFG_NAME_LOW:  name_low_r  <= cfg_data;
        cpv_pkg::CFG_NAME_MID:  name_mid_r  <= cfg_data;
        cpv_pkg::CFG_NAME_HIGH: name_high_r <= cfg_data[55:0];
        cpv_pkg::CFG_NAME_LEN:  name_len_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // byte 0 of the name sits in the low bits
  assign cfg.name     = {name_high_r, name_mid_r, name_low_r};
  assign cfg.name_len = name_len_r;

endmodule

/* src/cpv_parser.sv */
module cpv_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  cpv_pkg::cpv_in_t       item,
  input  cpv_pkg::cpv_cfg_t      cfg,
  output cpv_pkg::cpv_verdict_t  vd
);

  cpv_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  dlo_r, dlo_nxt;
  logic        fmt_r, fmt_nxt;
  logic [15:0] avail_r, avail_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic [4:0]  fnl_r, fnl_nxt;
  logic [15:0] fzp_r, fzp_nxt;
  logic        zs_r, zs_nxt;
  logic [4:0]  ms_r, ms_nxt;
  logic [4:0]  sl_r, sl_nxt;
  logic [15:0] last_r, last_nxt;
  logic [15:0] mlen_r, mlen_nxt;

  logic [7:0]  b;
  logic        is_zero;
  logic [15:0] pos_inc;
  logic [15:0] t;
  logic [15:0] m;
  logic [15:0] len_full;
  logic [4:0]  sl_cap;
  logic [4:0]  hdr_ms;
  logic [15:0] hdr_base;
  logic [15:0] hdr_min;
  logic        in_name;
  logic [7:0]  want;
  logic [7:0]  name_sel;
  logic        emit;
  logic [2:0]  st;

  localparam logic [4:0] NameField = 5'(cpv_pkg::NAME_FIELD_BYTES);
  localparam logic [4:0] NameMax   = 5'(cpv_pkg::NAME_MAX_BYTES);

  function automatic logic [7:0] name_byte(
    input logic [cpv_pkg::NAME_MAX_BYTES*8-1:0] name,
    input logic [4:0]                           idx
  );
    logic [7:0] nb;
    nb = '0;
    for (int i = 0; i < cpv_pkg::NAME_MAX_BYTES; i++) begin
      if (idx == 5'(i)) nb = name[i*8 +: 8];
    end
    return nb;
  endfunction

  assign b        = item.data_byte;
  assign is_zero  = (b == cpv_pkg::CHAR_NUL);
  assign pos_inc  = pos_r + 16'd1;
  assign t        = pos_inc - 16'(cpv_pkg::HEADER_BYTES);
  assign m        = t - {11'b0, ms_r};
  assign len_full = {b, dlo_r};
  assign sl_cap   = (cfg.name_len > NameMax) ? NameMax : cfg.name_len;
  assign hdr_ms   = fmt_r ? NameField : (sl_cap + 5'd3);
  assign hdr_base = {11'b0, hdr_ms} + 16'(cpv_pkg::HEADER_BYTES);
  assign hdr_min  = hdr_base + {15'b0, fmt_r};
  assign in_name  = (t < {11'b0, ms_r});
  assign name_sel = name_byte(cfg.name, t[4:0]);

  always_comb begin
    if (t[4:0] < sl_r) begin
      want = name_sel;
    end else if (t[4:0] == sl_r + 5'd1) begin
      want = cpv_pkg::CHAR_COLON;
    end else begin
      want = cpv_pkg::CHAR_SPACE;
    end
  end

  // datapath and verdict
  always_comb begin
    pos_nxt   = pos_r;
    dlo_nxt   = dlo_r;
    fmt_nxt   = fmt_r;
    avail_nxt = avail_r;
    pend_nxt  = pend_r;
    fnl_nxt   = fnl_r;
    fzp_nxt   = fzp_r;
    zs_nxt    = zs_r;
    ms_nxt    = ms_r;
    sl_nxt    = sl_r;
    last_nxt  = last_r;
    mlen_nxt  = mlen_r;
    emit      = 1'b0;
    st        = cpv_pkg::ST_OK;
    if (item.packet_start) begin
      pos_nxt   = '0;
      dlo_nxt   = '0;
      fmt_nxt   = item.packet_format;
      avail_nxt = item.bytes_available;
      pend_nxt  = cpv_pkg::ST_OK;
      fnl_nxt   = '0;
      fzp_nxt   = '0;
      zs_nxt    = 1'b0;
      ms_nxt    = '0;
    end else if (phase_r == cpv_pkg::PH_HEADER) begin
      pos_nxt = pos_inc;
      if (pos_inc == 16'd2) begin
        dlo_nxt = b;
      end else if (pos_inc == 16'd3) begin
        sl_nxt   = sl_cap;
        ms_nxt   = hdr_ms;
        last_nxt = len_full - 16'd1;
        mlen_nxt = len_full - hdr_base;
        if (!fmt_r) fnl_nxt = sl_cap;
        if (len_full > avail_r) begin
          emit = 1'b1;
          st   = cpv_pkg::ST_OVER_AVAIL;
        end else if (len_full < 16'(cpv_pkg::MIN_PACKET_BYTES)) begin
          emit = 1'b1;
          st   = cpv_pkg::ST_UNDER_MIN;
        end else if (len_full < hdr_min) begin
          emit = 1'b1;
          st   = fmt_r ? cpv_pkg::ST_NAME_SHORT : cpv_pkg::ST_LEN_MISMATCH;
        end
      end
    end else if (phase_r == cpv_pkg::PH_BODY) begin
      pos_nxt = pos_inc;
      if (in_name) begin
        if (!fmt_r) begin
          if (b != want && pend_nxt == cpv_pkg::ST_OK) pend_nxt = cpv_pkg::ST_NAME_MISMATCH;
        end else begin
          if (is_zero && !zs_r) begin
            zs_nxt  = 1'b1;
            fnl_nxt = t[4:0];
          end
          if (t[4:0] == NameField - 5'd1) begin
            if (!zs_nxt && pend_nxt == cpv_pkg::ST_OK) pend_nxt = cpv_pkg::ST_NAME_UNTERM;
            zs_nxt = 1'b0;
          end
        end
      end else if (is_zero && !zs_r) begin
        zs_nxt  = 1'b1;
        fzp_nxt = m;
      end
      if (pos_inc == last_r) begin
        emit = 1'b1;
        if (pend_nxt != cpv_pkg::ST_OK) begin
          st = pend_nxt;
        end else if (mlen_r == 16'd0 || !zs_nxt || fzp_nxt != mlen_r - 16'd1) begin
          st = cpv_pkg::ST_LEN_MISMATCH;
        end else if (mlen_r > 16'(cpv_pkg::MAX_MESSAGE_BYTES)) begin
          st = cpv_pkg::ST_TOO_LONG;
        end
      end
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      cpv_pkg::PH_IDLE: begin
        if (item.packet_start) phase_nxt = cpv_pkg::PH_HEADER;
      end
      cpv_pkg::PH_HEADER: begin
        if (item.packet_start) phase_nxt = cpv_pkg::PH_HEADER;
        else if (emit) phase_nxt = cpv_pkg::PH_IDLE;
        else if (pos_inc == 16'd3) phase_nxt = cpv_pkg::PH_BODY;
      end
      cpv_pkg::PH_BODY: begin
        if (item.packet_start) phase_nxt = cpv_pkg::PH_HEADER;
        else if (emit) phase_nxt = cpv_pkg::PH_IDLE;
      end
      default: phase_nxt = cpv_pkg::PH_IDLE;
    endcase
  end

  // verdict fields
  always_comb begin
    vd.emit                   = emit;
    vd.res.status             = st;
    vd.res.disconnect         = (st == cpv_pkg::ST_NAME_MISMATCH);
    vd.res.found_name_len     = '0;
    vd.res.message_offset     = '0;
    vd.res.message_length     = '0;
    if (st == cpv_pkg::ST_OK) begin
      vd.res.found_name_len = fnl_nxt;
      vd.res.message_offset = ms_r + 5'(cpv_pkg::HEADER_BYTES);
      vd.res.message_length = mlen_r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cpv_pkg::PH_IDLE;
      pos_r   <= '0;
      dlo_r   <= '0;
      fmt_r   <= 1'b0;
      avail_r <= '0;
      pend_r  <= cpv_pkg::ST_OK;
      fnl_r   <= '0;
      fzp_r   <= '0;
      zs_r    <= 1'b0;
      ms_r    <= '0;
      sl_r    <= '0;
      last_r  <= '0;
      mlen_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      dlo_r   <= dlo_nxt;
      fmt_r   <= fmt_nxt;
      avail_r <= avail_nxt;
      pend_r  <= pend_nxt;
      fnl_r   <= fnl_nxt;
      fzp_r   <= fzp_nxt;
      zs_r    <= zs_nxt;
      ms_r    <= ms_nxt;
      sl_r    <= sl_nxt;
      last_r  <= last_nxt;
      mlen_r  <= mlen_nxt;
    end
  end

endmodule

/* src/cpv_checker.sv */
module cpv_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input cpv_pkg::cpv_out_t out_data
);

  a_disconnect_tracks_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.disconnect == (out_data.status == cpv_pkg::ST_NAME_MISMATCH)))
    else $error("disconnect flag disagrees with status");

  a_reject_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != cpv_pkg::ST_OK) |->
      (out_data.found_name_len == 5'd0 && out_data.message_offset == 5'd0 &&
       out_data.message_length == 8'd0))
    else $error("rejected packet carries nonzero fields");

  a_ok_geometry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == cpv_pkg::ST_OK) |->
      (out_data.message_length != 8'd0 && out_data.message_offset >= 5'd7))
    else $error("accepted packet with impossible message geometry");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_stall_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

endmodule

bind chat_packet_validator_unit cpv_checker u_cpv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
